FILE: rtl/tdep_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tdep_pkg;

  localparam int EntryBytes = 12;

  localparam logic [1:0] CMD_CONT   = 2'd0;
  localparam logic [1:0] CMD_HEADER = 2'd1;
  localparam logic [1:0] CMD_DIR    = 2'd2;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_ENTRY  = 2'd1;
  localparam logic [1:0] KIND_NEXT   = 2'd2;
  localparam logic [1:0] KIND_BAD    = 2'd3;

  localparam logic [15:0] TYPE_SHORT     = 16'd3;
  localparam logic [15:0] TYPE_SSHORT    = 16'd8;
  localparam logic [15:0] TYPE_LONG      = 16'd4;
  localparam logic [15:0] TYPE_SLONG     = 16'd9;
  localparam logic [15:0] TYPE_FLOAT     = 16'd11;
  localparam logic [15:0] TYPE_RATIONAL  = 16'd5;
  localparam logic [15:0] TYPE_SRATIONAL = 16'd10;
  localparam logic [15:0] TYPE_DOUBLE    = 16'd12;

  localparam logic [7:0]  CHAR_M     = 8'h4D;
  localparam logic [7:0]  CHAR_I     = 8'h49;
  localparam logic [15:0] SUBDIR_TAG = 16'd330;
  localparam logic [31:0] MIN_OFFSET = 32'd8;

  localparam logic [3:0] IDX_MARK   = 4'd2;
  localparam logic [3:0] IDX_HEADER = 4'd8;
  localparam logic [3:0] IDX_COUNT  = 4'd2;
  localparam logic [3:0] IDX_NEXT   = 4'd4;
  localparam logic [3:0] IDX_ENTRY  = 4'd12;

  typedef logic [EntryBytes-1:0][7:0] tdep_buf_t;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_HDR  = 5'b00010,
    PH_CNT  = 5'b00100,
    PH_ENT  = 5'b01000,
    PH_NEXT = 5'b10000
  } tdep_phase_t;

  typedef struct packed {
    logic [15:0] tag_id;
    logic [15:0] field_type;
    logic [31:0] value_count;
    logic [34:0] byte_length;
    logic        value_inline;
    logic [31:0] scalar_value;
    logic        sub_directory;
    logic [31:0] value_word;
  } tdep_entry_t;

  // packed so that big_endian sits in the lowest bit
  typedef struct packed {
    logic        sub_directory;
    logic [31:0] scalar_value;
    logic        value_inline;
    logic [34:0] byte_length;
    logic [31:0] value_count;
    logic [15:0] field_type;
    logic [15:0] tag_id;
    logic        header_ok;
    logic [31:0] offset_word;
    logic        big_endian;
  } tdep_payload_t;

  typedef struct packed {
    logic [1:0]    kind;
    tdep_payload_t payload;
  } tdep_result_t;

  function automatic logic [15:0] rd16(input logic [7:0] b0, input logic [7:0] b1,
                                       input logic be);
    return be ? {b0, b1} : {b1, b0};
  endfunction

  function automatic logic [31:0] rd32(input logic [7:0] b0, input logic [7:0] b1,
                                       input logic [7:0] b2, input logic [7:0] b3,
                                       input logic be);
    return be ? {b0, b1, b2, b3} : {b3, b2, b1, b0};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/tdep_entry_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module tdep_entry_decode
  import tdep_pkg::*;
(
  input  tdep_buf_t   bytes,
  input  logic        big_endian,
  output tdep_entry_t entry
);

  logic [1:0]  size_log2;
  logic [15:0] tag;
  logic [15:0] ftype;
  logic [31:0] count;
  logic [31:0] word;
  logic [34:0] len;
  logic        inl;

  always_comb begin
    tag   = rd16(bytes[0], bytes[1], big_endian);
    ftype = rd16(bytes[2], bytes[3], big_endian);
    count = rd32(bytes[4], bytes[5], bytes[6], bytes[7], big_endian);
    word  = rd32(bytes[8], bytes[9], bytes[10], bytes[11], big_endian);

    unique case (ftype)
      TYPE_SHORT, TYPE_SSHORT:                  size_log2 = 2'd1;
      TYPE_LONG, TYPE_SLONG, TYPE_FLOAT:        size_log2 = 2'd2;
      TYPE_RATIONAL, TYPE_SRATIONAL, TYPE_DOUBLE: size_log2 = 2'd3;
      default:                                  size_log2 = 2'd0;
    endcase

    len = {3'b000, count} << size_log2;
    inl = (len != 35'd0) && (len <= 35'd4);

    entry.tag_id        = tag;
    entry.field_type    = ftype;
    entry.value_count   = count;
    entry.byte_length   = len;
    entry.value_inline  = inl;
    entry.sub_directory = (tag == SUBDIR_TAG);
    entry.value_word    = word;
    if (!inl) begin
      entry.scalar_value = 32'd0;
    end else if (size_log2 == 2'd1) begin
      entry.scalar_value = {16'd0, rd16(bytes[8], bytes[9], big_endian)};
    end else if (size_log2 == 2'd0) begin
      entry.scalar_value = {24'd0, bytes[8]};
    end else begin
      entry.scalar_value = word;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tiff_directory_entry_parser_core.sv
// Channel   Dir  Width  Contents
// s_*       in   8/2    tdata: data_byte; tuser: cmd
// m_*       out  168/2  tdata: parse result fields; tuser: kind
//
// One byte is taken per cycle while s_tready is high. A finished result goes
// to the output register, or to the skid register while m_* waits, so bytes
// keep flowing; s_tready drops only when both registers are full.
// rst is synchronous: parser goes idle, little endian, no results pending.
`timescale 1ns / 1ps
`default_nettype none

module tiff_directory_entry_parser_core
  import tdep_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] data_byte
  input  logic [1:0]   s_tuser,   // [1:0] cmd
  output logic         m_tvalid,
  input  logic         m_tready,
  // [0] big_endian, [32:1] offset_word, [33] header_ok, [49:34] tag_id,
  // [65:50] field_type, [97:66] value_count, [132:98] byte_length,
  // [133] value_inline, [165:134] scalar_value, [166] sub_directory, [167] zero
  output logic [167:0] m_tdata,
  output logic [1:0]   m_tuser    // [1:0] kind
);

  tdep_phase_t  phase, phase_next, ph_eff;
  logic [3:0]   byte_index, byte_index_next, idx_eff, idx_w, idx_inc;
  logic         byte_order, byte_order_next;
  logic [15:0]  entries_left, entries_left_next;
  tdep_buf_t    entry_buffer;
  tdep_buf_t    view;
  tdep_entry_t  entry;
  tdep_result_t res;
  logic         has_res;
  logic         accept;
  logic [31:0]  word32;

  tdep_result_t out_res, skid_res;
  logic         out_valid, skid_valid;

  assign accept = s_tvalid && s_tready;

  always_comb begin
    if (s_tuser == CMD_HEADER) begin
      ph_eff  = PH_HDR;
      idx_eff = 4'd0;
    end else if (s_tuser == CMD_DIR) begin
      ph_eff  = PH_CNT;
      idx_eff = 4'd0;
    end else begin
      ph_eff  = phase;
      idx_eff = byte_index;
    end
    idx_w   = (idx_eff >= IDX_ENTRY) ? 4'd0 : idx_eff;
    idx_inc = idx_w + 4'd1;
    view        = entry_buffer;
    view[idx_w] = s_tdata;
  end

  tdep_entry_decode u_decode (
    .bytes      (view),
    .big_endian (byte_order),
    .entry      (entry)
  );

  always_comb begin
    phase_next        = phase;
    byte_index_next   = byte_index;
    byte_order_next   = byte_order;
    entries_left_next = entries_left;
    has_res           = 1'b0;
    res               = '0;
    word32            = '0;

    if (ph_eff != PH_IDLE) begin
      phase_next      = ph_eff;
      byte_index_next = idx_inc;
      unique case (ph_eff)
        PH_HDR: begin
          if (idx_inc == IDX_MARK) begin
            if (view[0] == CHAR_M && view[1] == CHAR_M) begin
              byte_order_next = 1'b1;
            end else if (view[0] == CHAR_I && view[1] == CHAR_I) begin
              byte_order_next = 1'b0;
            end else begin
              phase_next                 = PH_IDLE;
              byte_index_next            = 4'd0;
              has_res                    = 1'b1;
              res.kind                   = KIND_BAD;
              res.payload.big_endian     = byte_order;
            end
          end else if (idx_inc == IDX_HEADER) begin
            word32                     = rd32(view[4], view[5], view[6], view[7], byte_order);
            phase_next                 = PH_IDLE;
            byte_index_next            = 4'd0;
            has_res                    = 1'b1;
            res.kind                   = KIND_HEADER;
            res.payload.big_endian     = byte_order;
            res.payload.offset_word    = word32;
            res.payload.header_ok      = (word32 >= MIN_OFFSET);
          end
        end
        PH_CNT: begin
          if (idx_inc == IDX_COUNT) begin
            entries_left_next = rd16(view[0], view[1], byte_order);
            byte_index_next   = 4'd0;
            phase_next        = (entries_left_next != 16'd0) ? PH_ENT : PH_NEXT;
          end
        end
        PH_ENT: begin
          if (idx_inc == IDX_ENTRY) begin
            has_res                     = 1'b1;
            res.kind                    = KIND_ENTRY;
            res.payload.big_endian      = byte_order;
            res.payload.offset_word     = entry.value_word;
            res.payload.tag_id          = entry.tag_id;
            res.payload.field_type      = entry.field_type;
            res.payload.value_count     = entry.value_count;
            res.payload.byte_length     = entry.byte_length;
            res.payload.value_inline    = entry.value_inline;
            res.payload.scalar_value    = entry.scalar_value;
            res.payload.sub_directory   = entry.sub_directory;
            byte_index_next             = 4'd0;
            entries_left_next           = entries_left - 16'd1;
            if (entries_left_next == 16'd0) begin
              phase_next = PH_NEXT;
            end
          end
        end
        PH_NEXT: begin
          if (idx_inc == IDX_NEXT) begin
            has_res                 = 1'b1;
            res.kind                = KIND_NEXT;
            res.payload.big_endian  = byte_order;
            res.payload.offset_word = rd32(view[0], view[1], view[2], view[3], byte_order);
            phase_next              = PH_IDLE;
            byte_index_next         = 4'd0;
          end
        end
        default: begin
          phase_next      = PH_IDLE;
          byte_index_next = 4'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      byte_index   <= 4'd0;
      byte_order   <= 1'b0;
      entries_left <= 16'd0;
    end else if (accept) begin
      phase        <= phase_next;
      byte_index   <= byte_index_next;
      byte_order   <= byte_order_next;
      entries_left <= entries_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && ph_eff != PH_IDLE) begin
      entry_buffer[idx_w] <= s_tdata;
    end
  end

  // output register plus skid register
  assign s_tready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !m_tready) begin
      if (accept && has_res) begin
        skid_valid <= 1'b1;
        skid_res   <= res;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      out_res    <= skid_res;
      skid_valid <= accept && has_res;
      skid_res   <= res;
    end else begin
      out_valid <= accept && has_res;
      out_res   <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_res.payload};
  assign m_tuser  = out_res.kind;

endmodule

`default_nettype wire

FILE: rtl/tdep_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module tdep_checker
  import tdep_pkg::*;
(
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_tready,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [167:0] m_tdata,
  input wire logic [1:0]   m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid && s_tready)
    else $error("result present or input blocked after reset");

  a_bad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_BAD |-> m_tdata[167:1] == '0)
    else $error("bad mark result carries data");

  a_header: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_HEADER |->
      m_tdata[33] == (m_tdata[32:1] >= MIN_OFFSET) && m_tdata[167:34] == '0)
    else $error("header result inconsistent");

  a_inline: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_ENTRY |->
      m_tdata[133] == (m_tdata[132:98] != 35'd0 && m_tdata[132:98] <= 35'd4) &&
      (m_tdata[133] || m_tdata[165:134] == 32'd0))
    else $error("entry inline flag or scalar inconsistent");

endmodule

bind tiff_directory_entry_parser_core tdep_checker u_tdep_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

FILE: tb/tiff_directory_entry_parser_core_tb.sv
`timescale 1ns / 1ps

module tiff_directory_entry_parser_core_tb
  import tdep_pkg::*;
;

  localparam logic [1:0] CMD_ALT = 2'd3;  // behaves as a continuing byte

  localparam int TargetBytes = 1550;
  localparam int CycleLimit  = 200000;

  class tdep_scoreboard;
    logic        order_be;
    tdep_phase_t phase;
    int unsigned pos;
    logic [15:0] entries_left;
    logic [7:0]  buff [EntryBytes];
    tdep_result_t expected_q[$];
    int errors;

    function new();
      order_be = 1'b0;
      phase = PH_IDLE;
      pos = 0;
      entries_left = '0;
      foreach (buff[i]) buff[i] = '0;
      errors = 0;
    endfunction

    function logic [15:0] word16(int at);
      return order_be ? {buff[at], buff[at+1]} : {buff[at+1], buff[at]};
    endfunction

    function logic [31:0] word32(int at);
      return order_be ? {buff[at], buff[at+1], buff[at+2], buff[at+3]}
                      : {buff[at+3], buff[at+2], buff[at+1], buff[at]};
    endfunction

    function logic [3:0] type_bytes(logic [15:0] t);
      case (t)
        TYPE_SHORT, TYPE_SSHORT: return 4'd2;
        TYPE_LONG, TYPE_SLONG, TYPE_FLOAT: return 4'd4;
        TYPE_RATIONAL, TYPE_SRATIONAL, TYPE_DOUBLE: return 4'd8;
        default: return 4'd1;
      endcase
    endfunction

    function void decode_entry(output tdep_result_t r);
      logic [3:0] sz;
      r = '0;
      r.kind = KIND_ENTRY;
      r.payload.big_endian = order_be;
      r.payload.tag_id = word16(0);
      r.payload.field_type = word16(2);
      r.payload.value_count = word32(4);
      r.payload.offset_word = word32(8);
      sz = type_bytes(r.payload.field_type);
      r.payload.byte_length = 35'(sz) * 35'(r.payload.value_count);
      r.payload.value_inline = (r.payload.byte_length != 0) && (r.payload.byte_length <= 4);
      if (r.payload.value_inline) begin
        if (sz == 4'd2) r.payload.scalar_value = 32'(word16(8));
        else if (sz == 4'd1) r.payload.scalar_value = 32'(buff[8]);
        else r.payload.scalar_value = word32(8);
      end
      r.payload.sub_directory = (r.payload.tag_id == SUBDIR_TAG);
    endfunction

    function void note_byte(logic [1:0] cmd, logic [7:0] b);
      tdep_result_t r;
      r = '0;
      r.payload.big_endian = order_be;
      if (cmd == CMD_HEADER) begin
        phase = PH_HDR;
        pos = 0;
      end else if (cmd == CMD_DIR) begin
        phase = PH_CNT;
        pos = 0;
      end
      if (phase == PH_IDLE) return;
      if (pos >= EntryBytes) pos = 0;
      buff[pos] = b;
      pos++;
      case (phase)
        PH_HDR: begin
          if (pos == IDX_MARK) begin
            if (buff[0] == CHAR_M && buff[1] == CHAR_M) begin
              order_be = 1'b1;
            end else if (buff[0] == CHAR_I && buff[1] == CHAR_I) begin
              order_be = 1'b0;
            end else begin
              phase = PH_IDLE;
              pos = 0;
              r.kind = KIND_BAD;
              expected_q.push_back(r);
            end
          end else if (pos == IDX_HEADER) begin
            phase = PH_IDLE;
            pos = 0;
            r.kind = KIND_HEADER;
            r.payload.big_endian = order_be;
            r.payload.offset_word = word32(4);
            r.payload.header_ok = (r.payload.offset_word >= MIN_OFFSET);
            expected_q.push_back(r);
          end
        end
        PH_CNT: begin
          if (pos == IDX_COUNT) begin
            entries_left = word16(0);
            pos = 0;
            phase = (entries_left != 0) ? PH_ENT : PH_NEXT;
          end
        end
        PH_ENT: begin
          if (pos == IDX_ENTRY) begin
            decode_entry(r);
            expected_q.push_back(r);
            pos = 0;
            entries_left--;
            if (entries_left == 0) phase = PH_NEXT;
          end
        end
        PH_NEXT: begin
          if (pos == IDX_NEXT) begin
            r.kind = KIND_NEXT;
            r.payload.offset_word = word32(0);
            expected_q.push_back(r);
            phase = PH_IDLE;
            pos = 0;
          end
        end
        default: begin
          phase = PH_IDLE;
          pos = 0;
        end
      endcase
    endfunction

    function void compare(string name, logic [63:0] e, logic [63:0] a);
      if (e !== a) begin
        $display("%0t %s mismatch: expected %h, actual %h", $time, name, e, a);
        errors++;
      end
    endfunction

    function void check_result(logic [1:0] kind, logic [167:0] data);
      tdep_result_t e;
      tdep_payload_t a;
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result: expected none, actual kind %0d data %h",
                 $time, kind, data);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      a = tdep_payload_t'(data[166:0]);
      compare("kind", e.kind, kind);
      compare("big_endian", e.payload.big_endian, a.big_endian);
      compare("offset_word", e.payload.offset_word, a.offset_word);
      compare("header_ok", e.payload.header_ok, a.header_ok);
      compare("tag_id", e.payload.tag_id, a.tag_id);
      compare("field_type", e.payload.field_type, a.field_type);
      compare("value_count", e.payload.value_count, a.value_count);
      compare("byte_length", e.payload.byte_length, a.byte_length);
      compare("value_inline", e.payload.value_inline, a.value_inline);
      compare("scalar_value", e.payload.scalar_value, a.scalar_value);
      compare("sub_directory", e.payload.sub_directory, a.sub_directory);
      compare("pad", 64'd0, data[167]);
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [7:0]   s_tdata;
  logic [1:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [167:0] m_tdata;
  logic [1:0]   m_tuser;

  tdep_scoreboard sb = new();
  int   src_idle_pct = 32;
  int   snk_idle_pct = 32;
  int   bytes_sent = 0;
  int   cycles = 0;
  logic cur_be = 1'b0;
  logic [7:0] pkt[$];

  tiff_directory_entry_parser_core uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_byte(s_tuser, s_tdata);
      if (m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
    end
  end

  always @(negedge clk) begin
    if (!rst) m_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tiff_directory_entry_parser_core_tb NOT OK");
      $finish;
    end
  end

  task automatic send_byte(input logic [1:0] cmd, input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata <= 8'($urandom);
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  function automatic void add16(logic [15:0] v);
    if (cur_be) begin
      pkt.push_back(v[15:8]);
      pkt.push_back(v[7:0]);
    end else begin
      pkt.push_back(v[7:0]);
      pkt.push_back(v[15:8]);
    end
  endfunction

  function automatic void add32(logic [31:0] v);
    if (cur_be) begin
      add16(v[31:16]);
      add16(v[15:0]);
    end else begin
      add16(v[15:0]);
      add16(v[31:16]);
    end
  endfunction

  task automatic send_pkt(input logic [1:0] marker, input int keep);
    int n;
    logic [1:0] cmd;
    n = (keep < pkt.size()) ? keep : pkt.size();
    for (int i = 0; i < n; i++) begin
      cmd = (i == 0) ? marker : (($urandom_range(9) == 0) ? CMD_ALT : CMD_CONT);
      send_byte(cmd, pkt[i]);
      bytes_sent++;
      src_idle_pct = (bytes_sent >= 600 && bytes_sent < 900) ? 0 : 32;
      snk_idle_pct = src_idle_pct;
    end
    pkt.delete();
  endtask

  function automatic int pick_keep();
    return ($urandom_range(99) < 85) ? pkt.size() : $urandom_range(pkt.size() - 1, 1);
  endfunction

  function automatic logic [7:0] mark_byte();
    case ($urandom_range(2))
      0: return CHAR_I;
      1: return CHAR_M;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic header_seq(input bit mark_ok);
    logic [7:0] b0, b1;
    logic [31:0] off;
    if (mark_ok) begin
      b0 = $urandom_range(1) ? CHAR_M : CHAR_I;
      b1 = b0;
    end else begin
      b0 = mark_byte();
      b1 = mark_byte();
    end
    if (b0 == b1 && (b0 == CHAR_M || b0 == CHAR_I)) cur_be = (b0 == CHAR_M);
    pkt.push_back(b0);
    pkt.push_back(b1);
    add16(16'($urandom));
    case ($urandom_range(3))
      0: off = $urandom_range(15);
      1: off = 32'hFFFF_FFFF;
      default: off = $urandom;
    endcase
    add32(off);
    send_pkt(CMD_HEADER, pick_keep());
  endtask

  task automatic dir_seq();
    int cnt, nent;
    logic [31:0] vc;
    cnt = ($urandom_range(4) == 0) ? $urandom_range(65535) : $urandom_range(4);
    nent = (cnt > 4) ? $urandom_range(2) : cnt;
    add16(16'(cnt));
    for (int i = 0; i < nent; i++) begin
      add16(($urandom_range(3) == 0) ? SUBDIR_TAG : 16'($urandom));
      add16(($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(13)));
      case ($urandom_range(7))
        0: vc = 32'd0;
        1: vc = 32'd1;
        2: vc = 32'd2;
        3: vc = 32'd4;
        4: vc = 32'hFFFF_FFFF;
        5: vc = $urandom_range(8);
        default: vc = $urandom;
      endcase
      add32(vc);
      add32($urandom);
    end
    if (nent == cnt) add32($urandom);
    send_pkt(CMD_DIR, pick_keep());
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = CMD_CONT;
    m_tready = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // continuing bytes while idle
    send_byte(CMD_CONT, 8'hA5);
    send_byte(CMD_ALT, 8'h5A);
    // big endian header, offset below minimum
    cur_be = 1'b1;
    pkt.push_back(CHAR_M);
    pkt.push_back(CHAR_M);
    add16(16'h002A);
    add32(32'd7);
    send_pkt(CMD_HEADER, 8);
    // bad mark keeps byte order, trailing byte ignored
    pkt.push_back(CHAR_I);
    pkt.push_back(CHAR_M);
    send_pkt(CMD_HEADER, 2);
    send_byte(CMD_CONT, 8'hFF);
    // empty directory cut off inside the next offset by a new header
    add16(16'd0);
    add32(32'h1234_5678);
    send_pkt(CMD_DIR, 4);
    cur_be = 1'b0;
    pkt.push_back(CHAR_I);
    pkt.push_back(CHAR_I);
    add16(16'h002A);
    add32(32'hFFFF_FFFF);
    send_pkt(CMD_HEADER, 8);

    while (bytes_sent < TargetBytes) begin
      case ($urandom_range(9))
        0: begin
          repeat ($urandom_range(4, 1)) send_byte(2'($urandom), 8'($urandom));
        end
        1, 2, 3: header_seq($urandom_range(99) < 85);
        default: dir_seq();
      endcase
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tiff_directory_entry_parser_core_tb OK");
    end else begin
      $display("tiff_directory_entry_parser_core_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: tiff_directory_entry_parser_core.f
rtl/tdep_pkg.sv
rtl/tdep_entry_decode.sv
rtl/tiff_directory_entry_parser_core.sv
rtl/tdep_checker.sv
tb/tiff_directory_entry_parser_core_tb.sv
